[src/uvf_pkg.sv]
// ============================================================================
// uvf_pkg
// Shared constants and codes for the unique value queue: default depth,
// operation codes and result status codes.
// ============================================================================
package uvf_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int VALUE_W          = 31;
    localparam int IN_VALUE_W       = 32;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_POP    = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NEGATIVE  = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

endpackage

[src/unique_value_fifo.sv]
// ============================================================================
// unique_value_fifo
// First-in first-out queue of non-negative values that refuses duplicates.
// Entries live in one synchronous memory; an append scans the queued entries
// for a match before it writes the tail.
// ============================================================================
//
//  channel  direction  ports                                  word
//  -------  ---------  -------------------------------------  ----------------
//  s_       in         s_valid s_ready s_operation s_value    append or pop
//  m_       out        m_valid m_ready m_status m_result_value status, value
//
//  A pop passes through S_POP and S_RESP. An append of a non-negative value
//  goes through S_SCAN and S_RESP; the duplicate scan in S_SCAN reads one
//  entry per cycle through the single memory read port and stops at a match.
//  A negative append or an empty pop goes straight to S_RESP.
//  Synchronous reset empties the queue at once.
//  A stalled m_ channel holds one finished word; the next word is then taken
//  and worked on, and waits for the output register before it completes.
//
module unique_value_fifo #(
    parameter int CAPACITY = uvf_pkg::DEFAULT_CAPACITY
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic signed [uvf_pkg::IN_VALUE_W-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [uvf_pkg::VALUE_W-1:0]   m_result_value
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int VW    = uvf_pkg::VALUE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_RESP
    } state_t;

    logic [VW-1:0]    mem [CAPACITY];
    logic [VW-1:0]    rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    state_t            state_reg, state_next;
    logic [VW-1:0]     val_reg, val_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic              rd_pend_reg, rd_pend_next;
    uvf_pkg::status_t  res_status_reg, res_status_next;
    logic [VW-1:0]     res_value_reg, res_value_next;
    logic              m_valid_reg, m_valid_next;
    uvf_pkg::status_t  m_status_reg, m_status_next;
    logic [VW-1:0]     m_value_reg, m_value_next;

    logic              out_free;
    logic [IDX_W-1:0]  scan_slot;
    logic [IDX_W-1:0]  tail_slot;
    logic [IDX_W-1:0]  next_head;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] wrapped;
        begin
            sum = SUM_W'(base) + SUM_W'(off);
            wrapped = (sum >= SUM_W'(CAPACITY)) ? sum - SUM_W'(CAPACITY) : sum;
            return wrapped[IDX_W-1:0];
        end
    endfunction

    assign scan_slot = slot_of(head_reg, iss_reg);
    assign tail_slot = slot_of(head_reg, count_reg);
    assign next_head = slot_of(head_reg, CNT_W'(1));
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_result_value = m_value_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= val_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next      = state_reg;
        val_next        = val_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        iss_next        = iss_reg;
        rd_pend_next    = rd_pend_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_value_next    = m_value_reg;
        rd_addr         = head_reg;
        wr_en           = 1'b0;
        wr_addr         = tail_slot;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_value_next = '0;
                    if (s_operation == uvf_pkg::OP_POP) begin
                        if (count_reg == '0) begin
                            res_status_next = uvf_pkg::ST_EMPTY;
                            state_next      = S_RESP;
                        end else begin
                            state_next = S_POP;
                        end
                    end else if (s_value[uvf_pkg::IN_VALUE_W-1]) begin
                        res_status_next = uvf_pkg::ST_NEGATIVE;
                        state_next      = S_RESP;
                    end else begin
                        val_next     = s_value[VW-1:0];
                        iss_next     = '0;
                        rd_pend_next = 1'b0;
                        state_next   = S_SCAN;
                    end
                end
            end
            S_POP: begin
                res_status_next = uvf_pkg::ST_OK;
                res_value_next  = rd_data_reg;
                head_next       = next_head;
                count_next      = count_reg - CNT_W'(1);
                state_next      = S_RESP;
            end
            S_SCAN: begin
                rd_addr      = scan_slot;
                rd_pend_next = 1'b0;
                if (rd_pend_reg && (rd_data_reg == val_reg)) begin
                    res_status_next = uvf_pkg::ST_DUPLICATE;
                    state_next      = S_RESP;
                end else if (iss_reg == count_reg) begin
                    if (count_reg == CNT_W'(CAPACITY)) begin
                        res_status_next = uvf_pkg::ST_FULL;
                    end else begin
                        wr_en           = 1'b1;
                        count_next      = count_reg + CNT_W'(1);
                        res_status_next = uvf_pkg::ST_OK;
                        res_value_next  = val_reg;
                    end
                    state_next = S_RESP;
                end else begin
                    rd_pend_next = 1'b1;
                    iss_next     = iss_reg + CNT_W'(1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            iss_reg     <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            iss_reg     <= iss_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
    end

endmodule

[tb/sv/unique_value_fifo_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// unique_value_fifo_tb
// Self-checking bench for the duplicate-rejecting queue. A behavioral queue
// predicts status and value for every accepted word; a monitor compares each
// returned word with the oldest prediction. Directed words cover the empty,
// negative, duplicate and full cases and the field extremes. Random traffic
// then runs under several idle and stall mixes, plus one long receiver hold.
// ============================================================================
module unique_value_fifo_tb;

    localparam int CAPACITY    = uvf_pkg::DEFAULT_CAPACITY;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 2 * (CAPACITY + 3);

    typedef struct packed {
        uvf_pkg::status_t            status;
        logic [uvf_pkg::VALUE_W-1:0] value;
    } response_t;

    logic                                  aclk           = 1'b0;
    logic                                  aresetn        = 1'b0;
    logic                                  s_valid        = 1'b0;
    logic                                  s_ready;
    logic                                  s_operation    = 1'b0;
    logic signed [uvf_pkg::IN_VALUE_W-1:0] s_value        = '0;
    logic                                  m_valid;
    logic                                  m_ready        = 1'b0;
    logic [2:0]                            m_status;
    logic [uvf_pkg::VALUE_W-1:0]           m_result_value;

    logic [uvf_pkg::VALUE_W-1:0] model_slots [CAPACITY];
    int                          model_head  = 0;
    int                          model_count = 0;

    response_t pending_responses [$];
    int        mismatch_count  = 0;
    int        send_idle_pct   = 0;
    int        recv_stall_pct  = 0;
    logic      receiver_held   = 1'b0;
    event      hold_trigger;

    unique_value_fifo #(.CAPACITY(CAPACITY)) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_result_value (m_result_value)
    );

    always #5 aclk = ~aclk;

    function automatic response_t predict_response(uvf_pkg::op_t op,
                                                   logic [uvf_pkg::IN_VALUE_W-1:0] val);
        response_t                   r;
        logic [uvf_pkg::VALUE_W-1:0] v;
        bit                          found;
        r.status = uvf_pkg::ST_OK;
        r.value  = '0;
        v        = val[uvf_pkg::VALUE_W-1:0];
        found    = 1'b0;
        if (op == uvf_pkg::OP_APPEND) begin
            for (int k = 0; k < model_count; k++) begin
                if (model_slots[(model_head + k) % CAPACITY] == v) found = 1'b1;
            end
            if (val[uvf_pkg::IN_VALUE_W-1]) begin
                r.status = uvf_pkg::ST_NEGATIVE;
            end else if (found) begin
                r.status = uvf_pkg::ST_DUPLICATE;
            end else if (model_count >= CAPACITY) begin
                r.status = uvf_pkg::ST_FULL;
            end else begin
                model_slots[(model_head + model_count) % CAPACITY] = v;
                model_count++;
                r.value = v;
            end
        end else if (model_count == 0) begin
            r.status = uvf_pkg::ST_EMPTY;
        end else begin
            r.value    = model_slots[model_head];
            model_head = (model_head + 1) % CAPACITY;
            model_count--;
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("[mismatch] t=%0t %s", $realtime, msg);
    endtask

    // Hold valid across back-to-back words; drop it only for an idle gap.
    task automatic send_word(uvf_pkg::op_t op, logic [uvf_pkg::IN_VALUE_W-1:0] val);
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value     <= val;
        do @(posedge aclk); while (!s_ready);
        pending_responses.push_back(predict_response(op, val));
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (pending_responses.size() != 0);
    endtask

    task automatic test_empty_pop();
        send_word(uvf_pkg::OP_POP, 32'hFFFF_FFFF);
    endtask

    task automatic test_append_extremes();
        send_word(uvf_pkg::OP_APPEND, 32'h0000_0000);
        send_word(uvf_pkg::OP_APPEND, 32'h7FFF_FFFF);
        send_word(uvf_pkg::OP_APPEND, 32'h8000_0000);
        send_word(uvf_pkg::OP_APPEND, 32'hFFFF_FFFF);
        send_word(uvf_pkg::OP_APPEND, 32'h0000_0000);
    endtask

    // Fill to capacity, then check that negative and duplicate win over full.
    task automatic test_full_and_order();
        for (int k = 0; k < CAPACITY - 2; k++) send_word(uvf_pkg::OP_APPEND, 32'h1 << k);
        send_word(uvf_pkg::OP_APPEND, 32'h1234_5678);
        send_word(uvf_pkg::OP_APPEND, 32'h7FFF_FFFF);
        send_word(uvf_pkg::OP_APPEND, 32'hFFFF_FFFB);
        send_word(uvf_pkg::OP_POP, 32'h0000_0000);
    endtask

    task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
        int                             pop_pct;
        int                             pick;
        uvf_pkg::op_t                   op;
        logic [uvf_pkg::IN_VALUE_W-1:0] val;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        pop_pct        = 50;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) pop_pct = $urandom_range(20, 80);
            op   = ($urandom_range(99) < pop_pct) ? uvf_pkg::OP_POP : uvf_pkg::OP_APPEND;
            pick = $urandom_range(99);
            if (pick < 10) begin
                val = $urandom | 32'h8000_0000;
            end else if (pick < 35 && model_count != 0) begin
                val = {1'b0, model_slots[(model_head + $urandom_range(model_count - 1))
                                         % CAPACITY]};
            end else if (pick < 70) begin
                val = $urandom_range(47);
            end else begin
                val = $urandom & 32'h7FFF_FFFF;
            end
            send_word(op, val);
        end
        s_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_backpressure_fill();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> hold_trigger;
        for (int i = 0; i < 24; i++) begin
            send_word((i % 6 == 5) ? uvf_pkg::OP_POP : uvf_pkg::OP_APPEND, 32'd1000 + i);
        end
        s_valid <= 1'b0;
        wait_drained();
    endtask

    always begin
        @(hold_trigger);
        receiver_held <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        receiver_held <= 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= !receiver_held && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : check_words
        response_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_responses.size() == 0) begin
                report_mismatch($sformatf("unexpected word status=%0d value=%0d",
                                          m_status, m_result_value));
            end else begin
                want = pending_responses.pop_front();
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              m_status, want.status));
                if (m_result_value !== want.value)
                    report_mismatch($sformatf("value %0d, want %0d",
                                              m_result_value, want.value));
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_pop();
        test_append_extremes();
        test_full_and_order();
        s_valid <= 1'b0;
        wait_drained();
        test_random_traffic(175, 0, 0);
        test_backpressure_fill();
        test_random_traffic(175, 55, 0);
        test_random_traffic(175, 0, 55);
        test_random_traffic(175, 19, 19);
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0 && pending_responses.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
